[src/abp_pkg.sv]
`default_nettype none
package abp_pkg;

  // Square of full alpha: source alpha is src_alpha*opacity over this.
  localparam logic [15:0] ALPHA_SQ = 16'd65025;

  // Alpha rounds (2W + S) / (2S): multiply by ceil(2**42 / 130050), keep bits 42 up.
  // Exact for numerators below 2**25.
  localparam logic [25:0] ALPHA_RECIP = 26'd33818121;
  localparam int          ALPHA_SHIFT = 42;

  // Divider widths: numerator 2n+w, denominator 2w, 8-bit quotient.
  localparam int NUM_W = 33;
  localparam int DEN_W = 25;
  localparam int Q_W   = 8;

  // Configuration register indexes.
  localparam logic CFG_OPACITY  = 1'b0;
  localparam logic CFG_CHANNELS = 1'b1;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       pixel_written;
  } pix_out_t;

  // Per-pixel flags and raw pixel carried alongside the arithmetic.
  typedef struct packed {
    logic    copy;
    logic    ch2;
    logic    ch4;
    logic    wzero;
    pix_in_t pix;
  } side_t;

endpackage
`default_nettype wire

[src/alpha_over_pixel_blend.sv]
`default_nettype none
// A new pixel is accepted while earlier ones are still in the pipe, one pixel per cycle
// sustained while results are taken.
// Four arithmetic stages feed an eight-stage divider per colour that resolves one quotient
// bit per stage; alpha divides by a constant through a reciprocal multiply beside the first
// divider stage. One output register follows. A stall on the result side holds every stage
// at once, so the throughput is one pixel per cycle while taken.
// Reset (synchronous, rst high): clears all valid bits, opacity to 255 and
// channel count to 4.
module alpha_over_pixel_blend (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pix_valid,
  output logic                   pix_ready,
  input  wire abp_pkg::pix_in_t  pix,
  output logic                   blend_valid,
  input  wire logic              blend_ready,
  output abp_pkg::pix_out_t      blend,
  input  wire logic              wr_en,
  input  wire logic              wr_index,
  input  wire logic [7:0]        wr_data
);

  localparam int NW = abp_pkg::NUM_W;
  localparam int DW = abp_pkg::DEN_W;
  localparam int QW = abp_pkg::Q_W;
  localparam int AS = abp_pkg::ALPHA_SHIFT;
  // Four arithmetic stages plus one per quotient bit.
  localparam int NV = 4 + QW;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [7:0] opacity;
  logic [2:0] channels;

  always_ff @(posedge clk) begin
    if (rst) begin
      opacity  <= 8'd255;
      channels <= 3'd4;
    end else if (wr_en) begin
      unique case (wr_index)
        abp_pkg::CFG_OPACITY:  opacity  <= wr_data;
        abp_pkg::CFG_CHANNELS: channels <= wr_data[2:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: one enable for the whole pipe. Advance whenever the
  // output register is empty or its transfer completes; otherwise hold.
  // Refuse pixels while reset is applied.
  // ---------------------------------------------------------------------
  logic          en;
  logic [NV-1:0] vld;

  assign en        = !blend_valid || blend_ready;
  assign pix_ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld         <= '0;
      blend_valid <= 1'b0;
    end else if (en) begin
      vld         <= {vld[NV-2:0], pix_valid};
      blend_valid <= vld[NV-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: scaled source alpha A = src_alpha*opacity, destination weight.
  // ---------------------------------------------------------------------
  logic [15:0]    s1_a;
  logic [7:0]     s1_dw;
  abp_pkg::side_t s1_side;
  logic           ch4_in;

  assign ch4_in = channels >= 3'd4;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a          <= 16'(pix.src_alpha * opacity);
      // Three channels: destination counts as opaque.
      s1_dw         <= ch4_in ? pix.dst_alpha : 8'd255;
      s1_side.copy  <= channels < 3'd3;
      s1_side.ch2   <= channels == 3'd2;
      s1_side.ch4   <= ch4_in;
      s1_side.wzero <= 1'b0;
      s1_side.pix   <= pix;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: source weight 255*A and destination weight D*(S - A).
  // ---------------------------------------------------------------------
  logic [23:0]    s2_ws;
  logic [23:0]    s2_wd;
  abp_pkg::side_t s2_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ws   <= ({8'd0, s1_a} << 8) - {8'd0, s1_a};
      s2_wd   <= 24'(s1_dw * (abp_pkg::ALPHA_SQ - s1_a));
      s2_side <= s1_side;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: total weight W and the per-colour weighted products.
  // ---------------------------------------------------------------------
  logic [24:0]    wsum;
  logic [23:0]    s3_w;
  logic [31:0]    s3_ps [0:2];
  logic [31:0]    s3_pd [0:2];
  abp_pkg::side_t s3_side;

  assign wsum = {1'b0, s2_ws} + {1'b0, s2_wd};

  always_ff @(posedge clk) begin
    if (en) begin
      s3_w     <= wsum[23:0];
      s3_ps[0] <= 32'(s2_side.pix.src_red   * s2_ws);
      s3_ps[1] <= 32'(s2_side.pix.src_green * s2_ws);
      s3_ps[2] <= 32'(s2_side.pix.src_blue  * s2_ws);
      s3_pd[0] <= 32'(s2_side.pix.dst_red   * s2_wd);
      s3_pd[1] <= 32'(s2_side.pix.dst_green * s2_wd);
      s3_pd[2] <= 32'(s2_side.pix.dst_blue  * s2_wd);
      s3_side  <= s2_side;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: rounding numerators 2n + W over 2W; alpha is 2W + S over 2S.
  // ---------------------------------------------------------------------
  logic [NW-1:0]  s4_num [0:3];
  logic [DW-1:0]  s4_den;
  abp_pkg::side_t s4_side;
  logic [32:0]    nsum [0:2];

  for (genvar c = 0; c < 3; c++) begin : g_nsum
    assign nsum[c] = {1'b0, s3_ps[c]} + {1'b0, s3_pd[c]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        s4_num[c] <= {nsum[c][31:0], 1'b0} + {{(NW - 24){1'b0}}, s3_w};
      end
      s4_num[3] <= {{(NW - 25){1'b0}}, s3_w, 1'b0} + NW'(abp_pkg::ALPHA_SQ);
      s4_den    <= {s3_w, 1'b0};
      // Zero weight needs A = 0 and D = 0: leave the pixel as it is.
      s4_side   <= {s3_side.copy, s3_side.ch2, s3_side.ch4, s3_w == 24'd0, s3_side.pix};
    end
  end

  // ---------------------------------------------------------------------
  // Divider lanes; the side data and the alpha quotient shift alongside,
  // one stage per bit.
  // ---------------------------------------------------------------------
  logic [QW-1:0]  quot [0:2];
  abp_pkg::side_t sd   [0:QW-1];
  logic [50:0]    alpha_prod;
  logic [QW-1:0]  alpha_q [0:QW-1];

  abp_divider u_div_red (
    .clk  (clk),
    .en   (en),
    .num  (s4_num[0]),
    .den  (s4_den),
    .quot (quot[0])
  );

  abp_divider u_div_green (
    .clk  (clk),
    .en   (en),
    .num  (s4_num[1]),
    .den  (s4_den),
    .quot (quot[1])
  );

  abp_divider u_div_blue (
    .clk  (clk),
    .en   (en),
    .num  (s4_num[2]),
    .den  (s4_den),
    .quot (quot[2])
  );

  // Alpha numerator stays below 2**25, so the reciprocal product is exact.
  assign alpha_prod = {26'd0, s4_num[3][24:0]} * {25'd0, abp_pkg::ALPHA_RECIP};

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0]      <= s4_side;
      alpha_q[0] <= alpha_prod[AS+QW-1:AS];
      for (int k = 1; k < QW; k++) begin
        sd[k]      <= sd[k-1];
        alpha_q[k] <= alpha_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output select and result register.
  // ---------------------------------------------------------------------
  abp_pkg::side_t    fin;
  abp_pkg::pix_out_t blend_next;

  assign fin = sd[QW-1];

  always_comb begin
    if (fin.copy) begin
      // Narrow framebuffer: copy the source channels it holds.
      blend_next.out_red       = fin.pix.src_red;
      blend_next.out_green     = fin.ch2 ? fin.pix.src_green : fin.pix.dst_green;
      blend_next.out_blue      = fin.pix.dst_blue;
      blend_next.out_alpha     = fin.pix.dst_alpha;
      blend_next.pixel_written = 1'b1;
    end else if (fin.wzero) begin
      blend_next.out_red       = fin.pix.dst_red;
      blend_next.out_green     = fin.pix.dst_green;
      blend_next.out_blue      = fin.pix.dst_blue;
      blend_next.out_alpha     = fin.pix.dst_alpha;
      blend_next.pixel_written = 1'b0;
    end else begin
      blend_next.out_red       = quot[0];
      blend_next.out_green     = quot[1];
      blend_next.out_blue      = quot[2];
      blend_next.out_alpha     = fin.ch4 ? alpha_q[QW-1] : fin.pix.dst_alpha;
      blend_next.pixel_written = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      blend <= blend_next;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // A transfer in always lands in the first stage.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready |=> vld[0])
    else $error("accepted pixel missing from first stage");

  // A stall holds every valid bit in place.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |=> $stable(vld))
    else $error("pipeline moved while stalled");

  // Every colour quotient fits in eight bits.
  a_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] && !s4_side.wzero |->
      ({1'b0, s4_num[0]} < ({{(NW + 1 - DW){1'b0}}, s4_den} << QW)) &&
      ({1'b0, s4_num[1]} < ({{(NW + 1 - DW){1'b0}}, s4_den} << QW)) &&
      ({1'b0, s4_num[2]} < ({{(NW + 1 - DW){1'b0}}, s4_den} << QW)))
    else $error("divider input out of quotient range");

endmodule
`default_nettype wire

[src/abp_divider.sv]
`default_nettype none
// Restoring divider, one quotient bit per register stage.
// Requires num < den * 2**Q_W.
module abp_divider (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [abp_pkg::NUM_W-1:0] num,
  input  wire logic [abp_pkg::DEN_W-1:0] den,
  output logic      [abp_pkg::Q_W-1:0]   quot
);

  localparam int NW = abp_pkg::NUM_W;
  localparam int DW = abp_pkg::DEN_W;
  localparam int QW = abp_pkg::Q_W;

  logic [NW-1:0] rem [0:QW];
  logic [DW-1:0] dn  [0:QW];
  logic [QW-1:0] q   [0:QW];

  assign rem[0] = num;
  assign dn[0]  = den;
  assign q[0]   = '0;

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int S = QW - 1 - k;
    logic [NW:0]   diff;
    logic [QW-1:0] q_next;

    assign diff = {1'b0, rem[k]} - ({{(NW + 1 - DW){1'b0}}, dn[k]} << S);

    always_comb begin
      q_next    = q[k];
      q_next[S] = ~diff[NW];
    end

    // Take the trial difference when it stays non-negative.
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= diff[NW] ? rem[k] : diff[NW-1:0];
        dn[k+1]  <= dn[k];
        q[k+1]   <= q_next;
      end
    end
  end

  assign quot = q[QW];

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int HALF_PERIOD = 4;
  // Latency of the blend pipe plus some slack.
  localparam int SETTLE = 20;
  localparam int LIMIT = 400000;
  localparam int PHASES = 10;
  localparam int PHASE_PIXELS = 200;

  // Channel counts with a meaning of their own.
  localparam logic [2:0] CH_RGB = 3'd3;
  localparam logic [2:0] CH_RGBA = 3'd4;
  localparam longint unsigned ALPHA_FULL_SQ = 65025;

  // Predicts blended pixels and checks them in transfer order.
  class blend_scoreboard;
    abp_pkg::pix_out_t blend_due[$];
    logic [7:0] opacity;
    logic [2:0] channels;
    int errors;

    function new();
      opacity = 8'd255;
      channels = CH_RGBA;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [7:0] val);
      if (idx == abp_pkg::CFG_OPACITY) opacity = val;
      else channels = val[2:0];
    endfunction

    function longint unsigned div_half_up(longint unsigned n, longint unsigned d);
      return (2 * n + d) / (2 * d);
    endfunction

    function abp_pkg::pix_out_t blend_over(abp_pkg::pix_in_t p);
      abp_pkg::pix_out_t r;
      longint unsigned a, dw, ws, wd, w;
      r.out_red = p.dst_red;
      r.out_green = p.dst_green;
      r.out_blue = p.dst_blue;
      r.out_alpha = p.dst_alpha;
      r.pixel_written = 1'b1;
      // Fewer than three channels: plain copy of red (and green with two).
      if (channels < CH_RGB) begin
        r.out_red = p.src_red;
        if (channels == 3'd2) r.out_green = p.src_green;
        return r;
      end
      a = longint'(p.src_alpha) * longint'(opacity);
      dw = (channels >= CH_RGBA) ? longint'(p.dst_alpha) : 255;
      ws = 255 * a;
      wd = dw * (ALPHA_FULL_SQ - a);
      w = ws + wd;
      // Nothing covers the pixel: leave the destination alone.
      if (w == 0) begin
        r.pixel_written = 1'b0;
        return r;
      end
      r.out_red = 8'(div_half_up(p.src_red * ws + p.dst_red * wd, w));
      r.out_green = 8'(div_half_up(p.src_green * ws + p.dst_green * wd, w));
      r.out_blue = 8'(div_half_up(p.src_blue * ws + p.dst_blue * wd, w));
      if (channels >= CH_RGBA) r.out_alpha = 8'(div_half_up(w, ALPHA_FULL_SQ));
      return r;
    endfunction

    function void note_pixel(abp_pkg::pix_in_t p);
      blend_due = {blend_due, blend_over(p)};
    endfunction

    function int pending();
      return blend_due.size();
    endfunction

    task report(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(abp_pkg::pix_out_t got);
      abp_pkg::pix_out_t want;
      if (blend_due.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      want = blend_due.pop_front();
      if (got.out_red !== want.out_red)
        report("out_red", int'(got.out_red), int'(want.out_red));
      if (got.out_green !== want.out_green)
        report("out_green", int'(got.out_green), int'(want.out_green));
      if (got.out_blue !== want.out_blue)
        report("out_blue", int'(got.out_blue), int'(want.out_blue));
      if (got.out_alpha !== want.out_alpha)
        report("out_alpha", int'(got.out_alpha), int'(want.out_alpha));
      if (got.pixel_written !== want.pixel_written)
        report("pixel_written", int'(got.pixel_written), int'(want.pixel_written));
    endtask
  endclass

  logic clk;
  logic rst;
  logic pix_valid;
  logic pix_ready;
  abp_pkg::pix_in_t pix;
  logic blend_valid;
  logic blend_ready;
  abp_pkg::pix_out_t blend;
  logic wr_en;
  logic wr_index;
  logic [7:0] wr_data;

  blend_scoreboard sb;
  int cycles;
  int gap_pct;
  int stall_pct;
  int stall_left;

  alpha_over_pixel_blend uut (
    .clk(clk),
    .rst(rst),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix(pix),
    .blend_valid(blend_valid),
    .blend_ready(blend_ready),
    .blend(blend),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && blend_valid && blend_ready) sb.check_result(blend);
  end

  // Result side back-pressure: hold ready low in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      blend_ready = 1'b0;
      stall_left--;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      blend_ready = 1'b0;
      stall_left = $urandom_range(1, 7) - 1;
    end else begin
      blend_ready = 1'b1;
    end
  end

  // Offer one pixel, optionally after a gap, and hold it until the transfer.
  // Called and returns at a falling edge; valid is left high for the next call.
  task automatic send_pixel(input abp_pkg::pix_in_t p);
    int gap;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 7);
      pix_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix = p;
    pix_valid = 1'b1;
    do @(posedge clk); while (!pix_ready);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic drain();
    pix_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    wr_index = idx;
    wr_data = val;
    wr_en = 1'b1;
    @(negedge clk);
    wr_en = 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Reconfigure only once the pipe is empty. Upper data bits of the channel
  // write are junk and must be dropped by the block.
  task automatic configure(input logic [7:0] op, input logic [2:0] ch);
    drain();
    write_reg(abp_pkg::CFG_OPACITY, op);
    write_reg(abp_pkg::CFG_CHANNELS, {5'($urandom), ch});
  endtask

  function automatic abp_pkg::pix_in_t make_pixel(int sr, int sg, int sbl, int sa,
                                                  int dr, int dg, int db, int da);
    abp_pkg::pix_in_t p;
    p = {8'(sr), 8'(sg), 8'(sbl), 8'(sa), 8'(dr), 8'(dg), 8'(db), 8'(da)};
    return p;
  endfunction

  // Alphas lean towards the extremes so that empty coverage and full
  // opacity come up often.
  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic abp_pkg::pix_in_t random_pixel();
    abp_pkg::pix_in_t p;
    p = abp_pkg::pix_in_t'({$urandom, $urandom});
    p.src_alpha = pick_alpha();
    p.dst_alpha = pick_alpha();
    return p;
  endfunction

  initial begin
    int op_tab[PHASES];
    logic [2:0] ch_tab[PHASES];
    logic [7:0] op;
    sb = new();
    cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    stall_left = 0;
    rst = 1'b1;
    pix_valid = 1'b0;
    pix = '0;
    wr_en = 1'b0;
    wr_index = abp_pkg::CFG_OPACITY;
    wr_data = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed part, reset settings first: full opacity, four channels.
    send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0));
    send_pixel(make_pixel(255, 255, 255, 255, 255, 255, 255, 255));
    send_pixel(make_pixel(200, 10, 99, 255, 3, 250, 77, 0));
    send_pixel(make_pixel(200, 10, 99, 0, 3, 250, 77, 255));
    send_pixel(make_pixel(255, 0, 128, 128, 0, 255, 127, 0));
    send_pixel(make_pixel(8'hAA, 8'h55, 8'hAA, 8'h80, 8'h55, 8'hAA, 8'h55, 8'h7F));
    // Opaque destination: zero alphas still cover the pixel.
    configure(8'd255, CH_RGB);
    send_pixel(make_pixel(9, 180, 255, 0, 40, 0, 255, 0));
    send_pixel(make_pixel(255, 0, 1, 100, 0, 255, 254, 33));
    // Zero opacity: only the destination alpha counts.
    configure(8'd0, CH_RGBA);
    send_pixel(make_pixel(255, 255, 255, 255, 1, 2, 3, 0));
    send_pixel(make_pixel(255, 255, 255, 255, 1, 2, 3, 200));
    // Copy modes.
    configure(8'd128, 3'd2);
    send_pixel(make_pixel(11, 22, 33, 44, 55, 66, 77, 88));
    configure(8'd128, 3'd1);
    send_pixel(make_pixel(11, 22, 33, 44, 55, 66, 77, 88));
    configure(8'd1, 3'd0);
    send_pixel(make_pixel(11, 22, 33, 0, 55, 66, 77, 0));
    // Counts above four behave like four.
    configure(8'd255, 3'd7);
    send_pixel(make_pixel(11, 22, 33, 0, 55, 66, 77, 0));
    send_pixel(make_pixel(250, 5, 130, 60, 5, 250, 20, 190));
    configure(8'd1, 3'd5);
    send_pixel(make_pixel(255, 255, 255, 255, 0, 0, 0, 0));

    // Random phases: every channel count, opacity at both extremes.
    op_tab = '{255, 0, 1, -1, 255, -1, 0, -1, 255, -1};
    ch_tab = '{CH_RGBA, CH_RGBA, CH_RGB, 3'd2, 3'd1, 3'd0, 3'd5, 3'd6, 3'd7, CH_RGBA};
    for (int ph = 0; ph < PHASES; ph++) begin
      op = (op_tab[ph] < 0) ? 8'($urandom_range(0, 255)) : 8'(op_tab[ph]);
      configure(op, ch_tab[ph]);
      // Vary the idling; leave the last phase and every third one quiet.
      if (ph == PHASES - 1 || ph % 3 == 0) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = (ph % 2 == 0) ? 35 : 12;
        stall_pct = (ph % 2 == 0) ? 12 : 35;
      end
      for (int i = 0; i < PHASE_PIXELS; i++) send_pixel(random_pixel());
    end

    pix_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
